[hw/rtl/two_channel_tone_sequencer_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the two-channel tone sequencer
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_TONE_SEQUENCER_TOP_ASSERT_SVH
`define TWO_CHANNEL_TONE_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Assertion that is switched off while reset is active.
`define TCTS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that is checked at every edge, reset included.
`define TCTS_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCTS_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define TCTS_ASSERT_ALL(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/tcts_pkg.sv]
// ----------------------------------------------------------------------------
// Tone sequencer package
// Widths, item types, action codes and the note tables of the tone sequencer.
// ----------------------------------------------------------------------------
package tcts_pkg;

    // Field and state widths.
    localparam int ACTION_W   = 3;
    localparam int EFFECT_W   = 4;
    localparam int FREQ_W     = 11;
    localparam int TICKS_W    = 2;
    localparam int TUNE_IDX_W = 6;
    localparam int FX_IDX_W   = 3;
    localparam int FX_CNT_W   = 4;

    // Sequencer limits.
    localparam int TUNE_LENGTH      = 40;
    localparam int MAX_EFFECT_NOTES = 8;
    localparam int EFFECT_COUNT     = 15;
    localparam int TUNE_ROM_NOTES   = 40;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SOUND_EN = 1'b0;

    // Note frequencies in Hz.
    localparam logic [FREQ_W-1:0] F_REST = 11'd0;
    localparam logic [FREQ_W-1:0] F_C5   = 11'd523;
    localparam logic [FREQ_W-1:0] F_D5   = 11'd587;
    localparam logic [FREQ_W-1:0] F_E5   = 11'd659;
    localparam logic [FREQ_W-1:0] F_F5   = 11'd698;
    localparam logic [FREQ_W-1:0] F_G5   = 11'd784;
    localparam logic [FREQ_W-1:0] F_A5   = 11'd880;
    localparam logic [FREQ_W-1:0] F_C6   = 11'd1046;
    localparam logic [FREQ_W-1:0] F_D6   = 11'd1175;
    localparam logic [FREQ_W-1:0] F_E6   = 11'd1318;
    localparam logic [FREQ_W-1:0] F_G6   = 11'd1568;
    localparam logic [FREQ_W-1:0] F_A6   = 11'd1760;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK      = 3'd0,
        ACT_EFFECT    = 3'd1,
        ACT_TUNE      = 3'd2,
        ACT_STOP_TUNE = 3'd3,
        ACT_STOP_ALL  = 3'd4
    } t_action;

    typedef struct packed {
        logic [FREQ_W-1:0]  hz;
        logic [TICKS_W-1:0] len;
    } t_note;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [EFFECT_W-1:0] effect_id;
        logic                speaker_owned;
    } t_item;

    typedef struct packed {
        logic                tone_on;
        logic [FREQ_W-1:0]   tone_freq;
        logic                tune_playing;
        logic [EFFECT_W-1:0] effect_playing;
    } t_result;

    // Tune table; entries past the end read as a silent empty note.
    function automatic t_note tune_note(input logic [TUNE_IDX_W-1:0] idx);
        t_note n;
        n = '{F_REST, 2'd0};
        case (idx)
            6'd0:  n = '{F_C5, 2'd1};
            6'd1:  n = '{F_E5, 2'd1};
            6'd2:  n = '{F_G5, 2'd1};
            6'd3:  n = '{F_C6, 2'd1};
            6'd4:  n = '{F_E6, 2'd1};
            6'd5:  n = '{F_G6, 2'd1};
            6'd6:  n = '{F_E6, 2'd1};
            6'd7:  n = '{F_C6, 2'd1};
            6'd8:  n = '{F_G5, 2'd1};
            6'd9:  n = '{F_C6, 2'd1};
            6'd10: n = '{F_E6, 2'd1};
            6'd11: n = '{F_G6, 2'd1};
            6'd12: n = '{F_A6, 2'd2};
            6'd13: n = '{F_G6, 2'd1};
            6'd14: n = '{F_E6, 2'd1};
            6'd15: n = '{F_C6, 2'd1};
            6'd16: n = '{F_G5, 2'd1};
            6'd17: n = '{F_E5, 2'd1};
            6'd18: n = '{F_G5, 2'd1};
            6'd19: n = '{F_C6, 2'd1};
            6'd20: n = '{F_E6, 2'd1};
            6'd21: n = '{F_G6, 2'd1};
            6'd22: n = '{F_REST, 2'd1};
            6'd23: n = '{F_E6, 2'd1};
            6'd24: n = '{F_D6, 2'd1};
            6'd25: n = '{F_C6, 2'd1};
            6'd26: n = '{F_G5, 2'd1};
            6'd27: n = '{F_E5, 2'd1};
            6'd28: n = '{F_G5, 2'd1};
            6'd29: n = '{F_C6, 2'd1};
            6'd30: n = '{F_REST, 2'd1};
            6'd31: n = '{F_G5, 2'd1};
            6'd32: n = '{F_C6, 2'd1};
            6'd33: n = '{F_E6, 2'd1};
            6'd34: n = '{F_G6, 2'd1};
            6'd35: n = '{F_C6, 2'd1};
            6'd36: n = '{F_E6, 2'd1};
            6'd37: n = '{F_G6, 2'd2};
            6'd38: n = '{F_C6, 2'd3};
            default: n = '{F_REST, 2'd0};
        endcase
        return n;
    endfunction

    // Number of notes in each effect; effect zero and fifteen are empty.
    function automatic logic [FX_CNT_W-1:0] fx_count(input logic [EFFECT_W-1:0] id);
        logic [FX_CNT_W-1:0] c;
        c = '0;
        case (id)
            4'd1:  c = 4'd1;
            4'd2:  c = 4'd2;
            4'd3:  c = 4'd4;
            4'd4:  c = 4'd2;
            4'd5:  c = 4'd2;
            4'd6:  c = 4'd2;
            4'd7:  c = 4'd3;
            4'd8:  c = 4'd2;
            4'd9:  c = 4'd1;
            4'd10: c = 4'd3;
            4'd11: c = 4'd4;
            4'd12: c = 4'd5;
            4'd13: c = 4'd4;
            4'd14: c = 4'd1;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    // Effect note table, looked up by effect number and note index.
    function automatic t_note fx_note(input logic [EFFECT_W-1:0] id,
                                      input logic [FX_IDX_W-1:0] idx);
        t_note n;
        n = '{F_REST, 2'd0};
        case ({id, idx})
            {4'd1,  3'd0}: n = '{F_C6, 2'd1};
            {4'd2,  3'd0}: n = '{F_E6, 2'd1};
            {4'd2,  3'd1}: n = '{F_G6, 2'd1};
            {4'd3,  3'd0}: n = '{F_C5, 2'd1};
            {4'd3,  3'd1}: n = '{F_E5, 2'd1};
            {4'd3,  3'd2}: n = '{F_G5, 2'd1};
            {4'd3,  3'd3}: n = '{F_C6, 2'd1};
            {4'd4,  3'd0}: n = '{F_E5, 2'd1};
            {4'd4,  3'd1}: n = '{F_G5, 2'd1};
            {4'd5,  3'd0}: n = '{F_C5, 2'd2};
            {4'd5,  3'd1}: n = '{F_G5, 2'd2};
            {4'd6,  3'd0}: n = '{F_E5, 2'd1};
            {4'd6,  3'd1}: n = '{F_C5, 2'd2};
            {4'd7,  3'd0}: n = '{F_A5, 2'd1};
            {4'd7,  3'd1}: n = '{F_G5, 2'd1};
            {4'd7,  3'd2}: n = '{F_F5, 2'd1};
            {4'd8,  3'd0}: n = '{F_G5, 2'd1};
            {4'd8,  3'd1}: n = '{F_C5, 2'd2};
            {4'd9,  3'd0}: n = '{F_D6, 2'd1};
            {4'd10, 3'd0}: n = '{F_E6, 2'd1};
            {4'd10, 3'd1}: n = '{F_C6, 2'd1};
            {4'd10, 3'd2}: n = '{F_G5, 2'd2};
            {4'd11, 3'd0}: n = '{F_C5, 2'd1};
            {4'd11, 3'd1}: n = '{F_E5, 2'd1};
            {4'd11, 3'd2}: n = '{F_G5, 2'd1};
            {4'd11, 3'd3}: n = '{F_C6, 2'd2};
            {4'd12, 3'd0}: n = '{F_C5, 2'd1};
            {4'd12, 3'd1}: n = '{F_D5, 2'd1};
            {4'd12, 3'd2}: n = '{F_E5, 2'd1};
            {4'd12, 3'd3}: n = '{F_G5, 2'd1};
            {4'd12, 3'd4}: n = '{F_C6, 2'd3};
            {4'd13, 3'd0}: n = '{F_A5, 2'd1};
            {4'd13, 3'd1}: n = '{F_F5, 2'd1};
            {4'd13, 3'd2}: n = '{F_D5, 2'd2};
            {4'd13, 3'd3}: n = '{F_C5, 2'd3};
            {4'd14, 3'd0}: n = '{F_G5, 2'd1};
            default: n = '{F_REST, 2'd0};
        endcase
        return n;
    endfunction

endpackage

[hw/rtl/tcts_apb.sv]
// ----------------------------------------------------------------------------
// Tone sequencer configuration port
// APB-style register file holding the global sound enable.
// ----------------------------------------------------------------------------
module tcts_apb (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcts_pkg::PADDR_W-1:0]        paddr,
    input  logic [tcts_pkg::PDATA_W-1:0]        pwdata,
    output logic [tcts_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    output logic                                o_sound_en
);

    logic r_sound_en;
    logic n_sound_en;
    logic sel_sound_en;

    // Register index sits above the byte offset.
    assign sel_sound_en = (paddr[tcts_pkg::PADDR_W-1:2] == tcts_pkg::REG_SOUND_EN);

    // A write lands in the access phase of the transfer.
    always_comb begin
        n_sound_en = r_sound_en;
        if (psel && penable && pwrite && pready && sel_sound_en) begin
            n_sound_en = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_en <= 1'b1;
        end else begin
            r_sound_en <= n_sound_en;
        end
    end

    // Read data for the addressed register.
    assign prdata     = sel_sound_en ? {{(tcts_pkg::PDATA_W-1){1'b0}}, r_sound_en} : '0;
    assign pready     = 1'b1;
    assign o_sound_en = r_sound_en;

endmodule

[hw/rtl/tcts_core.sv]
// ----------------------------------------------------------------------------
// Tone sequencer core
// Channel state registers and the single-pass next-state and tone logic.
// ----------------------------------------------------------------------------
module tcts_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  tcts_pkg::t_item   i_item,
    input  logic              i_sound_en,
    output tcts_pkg::t_result o_result
);

    logic [tcts_pkg::EFFECT_W-1:0]   r_effect,     n_effect;
    logic [tcts_pkg::FX_IDX_W-1:0]   r_fx_idx,     n_fx_idx;
    logic [tcts_pkg::TICKS_W-1:0]    r_fx_ticks,   n_fx_ticks;
    logic                            r_tune,       n_tune;
    logic [tcts_pkg::TUNE_IDX_W-1:0] r_tune_idx,   n_tune_idx;
    logic [tcts_pkg::TICKS_W-1:0]    r_tune_ticks, n_tune_ticks;
    logic                            r_sounding,   n_sounding;
    logic [tcts_pkg::FREQ_W-1:0]     r_freq,       n_freq;

    // Next state: apply the action, then the tick that it asks for.
    always_comb begin
        tcts_pkg::t_note             note;
        logic [tcts_pkg::FX_CNT_W-1:0] cnt;
        logic                        do_tick;
        logic                        can_sound;

        n_effect     = r_effect;
        n_fx_idx     = r_fx_idx;
        n_fx_ticks   = r_fx_ticks;
        n_tune       = r_tune;
        n_tune_idx   = r_tune_idx;
        n_tune_ticks = r_tune_ticks;
        n_sounding   = r_sounding;
        n_freq       = r_freq;
        do_tick      = 1'b0;
        note         = '0;
        cnt          = '0;
        can_sound    = i_sound_en && i_item.speaker_owned;

        unique case (tcts_pkg::t_action'(i_item.action))
            tcts_pkg::ACT_TICK: begin
                do_tick = 1'b1;
            end
            tcts_pkg::ACT_EFFECT: begin
                if (i_sound_en && (i_item.effect_id != '0) && !r_tune
                    && ({1'b0, i_item.effect_id} < (tcts_pkg::EFFECT_W + 1)'(tcts_pkg::EFFECT_COUNT))
                    && (tcts_pkg::fx_count(i_item.effect_id) != '0)) begin
                    n_effect   = i_item.effect_id;
                    n_fx_idx   = '0;
                    n_fx_ticks = '0;
                    do_tick    = 1'b1;
                end
            end
            tcts_pkg::ACT_TUNE: begin
                if (i_sound_en) begin
                    n_tune       = 1'b1;
                    n_tune_idx   = '0;
                    n_tune_ticks = '0;
                    n_effect     = '0;
                    n_fx_ticks   = '0;
                end
            end
            tcts_pkg::ACT_STOP_TUNE: begin
                n_tune       = 1'b0;
                n_tune_idx   = '0;
                n_tune_ticks = '0;
                n_sounding   = 1'b0;
                n_freq       = '0;
            end
            tcts_pkg::ACT_STOP_ALL: begin
                n_sounding   = 1'b0;
                n_freq       = '0;
                n_effect     = '0;
                n_fx_idx     = '0;
                n_fx_ticks   = '0;
                n_tune       = 1'b0;
                n_tune_idx   = '0;
                n_tune_ticks = '0;
            end
            default: begin
            end
        endcase

        // One tick: the tune channel has priority over the effect channel.
        if (do_tick) begin
            if (n_tune) begin
                if (n_tune_ticks == '0) begin
                    n_sounding = 1'b0;
                    n_freq     = '0;
                    if ((n_tune_idx >= tcts_pkg::TUNE_IDX_W'(tcts_pkg::TUNE_LENGTH))
                        || (n_tune_idx >= tcts_pkg::TUNE_IDX_W'(tcts_pkg::TUNE_ROM_NOTES))) begin
                        n_tune = 1'b0;
                    end else begin
                        note         = tcts_pkg::tune_note(n_tune_idx);
                        n_tune_idx   = n_tune_idx + 1'b1;
                        n_tune_ticks = (note.len == '0) ? '0 : note.len - 1'b1;
                        if ((note.hz != '0) && can_sound) begin
                            n_sounding = 1'b1;
                            n_freq     = note.hz;
                        end
                    end
                end else begin
                    n_tune_ticks = n_tune_ticks - 1'b1;
                    if (n_tune_ticks == '0) begin
                        n_sounding = 1'b0;
                        n_freq     = '0;
                    end
                end
            end else if (n_effect != '0) begin
                cnt = tcts_pkg::fx_count(n_effect);
                if (cnt > tcts_pkg::FX_CNT_W'(tcts_pkg::MAX_EFFECT_NOTES)) begin
                    cnt = tcts_pkg::FX_CNT_W'(tcts_pkg::MAX_EFFECT_NOTES);
                end
                if (cnt == '0) begin
                    n_effect = '0;
                end else if (n_fx_ticks == '0) begin
                    n_sounding = 1'b0;
                    n_freq     = '0;
                    if ({1'b0, n_fx_idx} >= cnt) begin
                        n_effect = '0;
                    end else begin
                        note       = tcts_pkg::fx_note(n_effect, n_fx_idx);
                        n_fx_idx   = n_fx_idx + 1'b1;
                        n_fx_ticks = (note.len == '0) ? '0 : note.len - 1'b1;
                        if ((note.hz != '0) && can_sound) begin
                            n_sounding = 1'b1;
                            n_freq     = note.hz;
                        end
                    end
                end else begin
                    n_fx_ticks = n_fx_ticks - 1'b1;
                    if (n_fx_ticks == '0) begin
                        n_sounding = 1'b0;
                        n_freq     = '0;
                    end
                end
            end
        end
    end

    // State advances only when an item is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect     <= '0;
            r_fx_idx     <= '0;
            r_fx_ticks   <= '0;
            r_tune       <= 1'b0;
            r_tune_idx   <= '0;
            r_tune_ticks <= '0;
            r_sounding   <= 1'b0;
            r_freq       <= '0;
        end else if (i_step) begin
            r_effect     <= n_effect;
            r_fx_idx     <= n_fx_idx;
            r_fx_ticks   <= n_fx_ticks;
            r_tune       <= n_tune;
            r_tune_idx   <= n_tune_idx;
            r_tune_ticks <= n_tune_ticks;
            r_sounding   <= n_sounding;
            r_freq       <= n_freq;
        end
    end

    // Result of the item being processed, taken from the next state.
    always_comb begin
        o_result.tone_on        = n_sounding;
        o_result.tone_freq      = n_sounding ? n_freq : '0;
        o_result.tune_playing   = n_tune;
        o_result.effect_playing = n_effect;
    end

endmodule

[hw/rtl/two_channel_tone_sequencer_top.sv]
// ----------------------------------------------------------------------------
// Two-channel tone sequencer
// Buzzer melody sequencer with a tune channel and a short-effect channel.
// ----------------------------------------------------------------------------
// The sequencer takes one action per transfer (tick, start effect, start tune,
// stop tune, stop all) and returns exactly one result per action: tone on,
// tone frequency, tune playing and the active effect number. It accepts one
// transfer every clock cycle unless the input side stalls; a result is offered
// on the output once its item has passed the input register and the result
// register, with a single combinational pass through the note tables feeding
// the result register. The input side stalls only while both the input and
// the result register are full and the output side stalls. The sound enable
// register sits at byte address 0 of the configuration port, resets to 1 and
// is to be written by the user only while idle; the block does not enforce it.
module two_channel_tone_sequencer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [tcts_pkg::ACTION_W-1:0]     i_action,
    input  logic [tcts_pkg::EFFECT_W-1:0]     i_effect_id,
    input  logic                              i_speaker_owned,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_tone_on,
    output logic [tcts_pkg::FREQ_W-1:0]       o_tone_freq,
    output logic                              o_tune_playing,
    output logic [tcts_pkg::EFFECT_W-1:0]     o_effect_playing,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcts_pkg::PADDR_W-1:0]      paddr,
    input  logic [tcts_pkg::PDATA_W-1:0]      pwdata,
    output logic [tcts_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

`include "two_channel_tone_sequencer_top_assert.svh"

    logic              r_in_valid;
    tcts_pkg::t_item   r_in;
    logic              r_out_valid;
    tcts_pkg::t_result r_res;
    tcts_pkg::t_result core_res;
    logic              sound_en;
    logic              advance;
    logic              step;

    // Pipeline moves unless a finished result is held by a stalled receiver.
    assign advance    = !(r_out_valid && i_out_stall);
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= '{action: i_action, effect_id: i_effect_id,
                      speaker_owned: i_speaker_owned};
        end
    end

    tcts_apb u_apb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_sound_en (sound_en)
    );

    tcts_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (r_in),
        .i_sound_en (sound_en),
        .o_result   (core_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_tone_on        = r_res.tone_on;
    assign o_tone_freq      = r_res.tone_freq;
    assign o_tune_playing   = r_res.tune_playing;
    assign o_effect_playing = r_res.effect_playing;

    // The input side only stalls behind a held, stalled result.
    `TCTS_ASSERT_ALL(a_stall_cause, i_clk, o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall), "input stall without a held result")
    // Stop all leaves both channels idle and the speaker silent.
    `TCTS_ASSERT_RST(a_stop_all_idle, i_clk, i_rst_n, (step && (r_in.action == tcts_pkg::ACT_STOP_ALL)) |=> (r_out_valid && !r_res.tone_on && !r_res.tune_playing && (r_res.effect_playing == '0)), "stop all did not silence")
    // The tune and an effect are never active together.
    `TCTS_ASSERT_RST(a_one_channel, i_clk, i_rst_n, (r_out_valid && r_res.tune_playing) |-> (r_res.effect_playing == '0), "tune and effect active together")
    // A silent result carries no frequency.
    `TCTS_ASSERT_RST(a_silent_freq, i_clk, i_rst_n, (r_out_valid && !r_res.tone_on) |-> (r_res.tone_freq == '0), "frequency reported while silent")

endmodule

[tb/two_channel_tone_sequencer_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the two-channel tone sequencer
// Drives tick, effect, tune and stop actions through the input channel and
// checks every tone report against a cycle-free model of the two channels.
// An opening table covers reset values, bad codes, refused tones and sound
// switched off mid-note; then about 1300 random actions follow, mostly
// effect and tune sequences, with bursty input, a patterned output stall,
// one long output hold-off and sound-enable writes between phases.
// ----------------------------------------------------------------------------
module testbench;
    import tcts_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int FX_SLOTS     = 8;

    // Action codes outside the defined set.
    localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

    // Effect numbers.
    localparam logic [EFFECT_W-1:0] FX_NONE   = 4'd0;
    localparam logic [EFFECT_W-1:0] FX_FIRST  = 4'd1;
    localparam logic [EFFECT_W-1:0] FX_CHIME  = 4'd2;
    localparam logic [EFFECT_W-1:0] FX_ARPEG  = 4'd3;
    localparam logic [EFFECT_W-1:0] FX_SCALE  = 4'd12;
    localparam logic [EFFECT_W-1:0] FX_FALL   = 4'd13;
    localparam logic [EFFECT_W-1:0] FX_LAST   = 4'd14;
    localparam logic [EFFECT_W-1:0] FX_UNUSED = 4'd15;

    localparam logic [PADDR_W-1:0] SOUND_EN_ADDR = PADDR_W'(int'(REG_SOUND_EN) * 4);

    // Reports that can be read straight off the tables.
    localparam t_result SILENT        = '0;
    localparam t_result TUNE_ONLY     = '{1'b0, F_REST, 1'b1, FX_NONE};
    localparam t_result FIRST_FX_NOTE = '{1'b1, F_C6, 1'b0, FX_FIRST};

    typedef struct packed {
        logic    is_cfg;
        logic    level;
        t_item   item;
        logic    typed;
        t_result want;
    } t_plan_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [ACTION_W-1:0] i_action;
    logic [EFFECT_W-1:0] i_effect_id;
    logic                i_speaker_owned;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_tone_on;
    logic [FREQ_W-1:0]   o_tone_freq;
    logic                o_tune_playing;
    logic [EFFECT_W-1:0] o_effect_playing;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    two_channel_tone_sequencer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_effect_id      (i_effect_id),
        .i_speaker_owned  (i_speaker_owned),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_tone_on        (o_tone_on),
        .o_tone_freq      (o_tone_freq),
        .o_tune_playing   (o_tune_playing),
        .o_effect_playing (o_effect_playing),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Tune notes: frequency and length in ticks; the last entry is an empty rest.
    logic [FREQ_W-1:0] tune_hz [0:39] = '{
        F_C5, F_E5, F_G5, F_C6, F_E6, F_G6, F_E6, F_C6,
        F_G5, F_C6, F_E6, F_G6, F_A6, F_G6, F_E6,
        F_C6, F_G5, F_E5, F_G5, F_C6, F_E6, F_G6, F_REST,
        F_E6, F_D6, F_C6, F_G5, F_E5, F_G5, F_C6, F_REST,
        F_G5, F_C6, F_E6, F_G6, F_C6, F_E6, F_G6, F_C6,
        F_REST
    };
    logic [TICKS_W-1:0] tune_len [0:39] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd3,
        2'd0
    };

    // Effect notes stored back to back; each effect has a first slot and a count.
    int fx_first [0:15] = '{0, 0, 1, 3, 7, 9, 11, 13, 16, 18, 19, 22, 26, 31, 35, 0};
    int fx_cnt   [0:15] = '{0, 1, 2, 4, 2, 2, 2, 3, 2, 1, 3, 4, 5, 4, 1, 0};
    logic [FREQ_W-1:0] fx_hz [0:35] = '{
        F_C6,
        F_E6, F_G6,
        F_C5, F_E5, F_G5, F_C6,
        F_E5, F_G5,
        F_C5, F_G5,
        F_E5, F_C5,
        F_A5, F_G5, F_F5,
        F_G5, F_C5,
        F_D6,
        F_E6, F_C6, F_G5,
        F_C5, F_E5, F_G5, F_C6,
        F_C5, F_D5, F_E5, F_G5, F_C6,
        F_A5, F_F5, F_D5, F_C5,
        F_G5
    };
    logic [TICKS_W-1:0] fx_len [0:35] = '{
        2'd1,
        2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1,
        2'd2, 2'd2,
        2'd1, 2'd2,
        2'd1, 2'd1, 2'd1,
        2'd1, 2'd2,
        2'd1,
        2'd1, 2'd1, 2'd2,
        2'd1, 2'd1, 2'd1, 2'd2,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd3,
        2'd1, 2'd1, 2'd2, 2'd3,
        2'd1
    };

    // Model state of the two channels and the speaker.
    logic                snd_en = 1'b1;
    logic                owned = 1'b0;
    logic [EFFECT_W-1:0] fx_sel = '0;
    logic [3:0]          fx_pos = '0;
    logic [TICKS_W-1:0]  fx_left = '0;
    logic                tune_on = 1'b0;
    logic [6:0]          tune_pos = '0;
    logic [TICKS_W-1:0]  tune_left = '0;
    logic                spk_on = 1'b0;
    logic [FREQ_W-1:0]   spk_hz = '0;

    t_result   tone_reports_due [$];
    t_plan_row opening_plan [$];
    t_item     melody_batch [$];
    t_result   report_want;

    bit hold_req = 1'b0;
    int burst_left = 0;
    int faults = 0;
    int actions_sent = 0;
    int reports_checked = 0;
    int settings_applied = 0;
    int effects_started = 0;
    int tunes_started = 0;
    int tunes_finished = 0;
    int cycle_count = 0;

    // Clock generation.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports still due", cycle_count,
                     tone_reports_due.size());
            $display("two_channel_tone_sequencer_top: mismatch");
            $finish;
        end
    end

    // A tone only starts when sound is enabled and the speaker is owned.
    task automatic tone_start(input logic [FREQ_W-1:0] hz);
        if (snd_en && owned) begin
            spk_on = 1'b1;
            spk_hz = hz;
        end
    endtask

    task automatic tone_stop();
        spk_on = 1'b0;
        spk_hz = '0;
    endtask

    // One tick: the tune channel has priority, the effect channel runs otherwise.
    task automatic tick_channels();
        int cnt;
        int slot;
        if (tune_on) begin
            if (tune_left == 0) begin
                tone_stop();
                if (tune_pos >= TUNE_LENGTH || tune_pos >= TUNE_ROM_NOTES) begin
                    tune_on = 1'b0;
                    tunes_finished++;
                end else begin
                    tune_left = tune_len[tune_pos];
                    if (tune_hz[tune_pos] != F_REST)
                        tone_start(tune_hz[tune_pos]);
                    tune_pos = tune_pos + 7'd1;
                    if (tune_left != 0)
                        tune_left = tune_left - 2'd1;
                end
            end else begin
                tune_left = tune_left - 2'd1;
                if (tune_left == 0)
                    tone_stop();
            end
        end else if (fx_sel != FX_NONE) begin
            cnt = fx_cnt[fx_sel];
            if (cnt > MAX_EFFECT_NOTES)
                cnt = MAX_EFFECT_NOTES;
            if (cnt == 0) begin
                fx_sel = FX_NONE;
            end else if (fx_left == 0) begin
                tone_stop();
                if (fx_pos >= cnt || fx_pos >= FX_SLOTS) begin
                    fx_sel = FX_NONE;
                end else begin
                    slot = fx_first[fx_sel] + int'(fx_pos);
                    fx_left = fx_len[slot];
                    if (fx_hz[slot] != F_REST)
                        tone_start(fx_hz[slot]);
                    fx_pos = fx_pos + 4'd1;
                    if (fx_left != 0)
                        fx_left = fx_left - 2'd1;
                end
            end else begin
                fx_left = fx_left - 2'd1;
                if (fx_left == 0)
                    tone_stop();
            end
        end
    endtask

    // Apply one action to the model and form the tone report it causes.
    task automatic advance_melody(input t_item it, output t_result rep);
        owned = it.speaker_owned;
        case (it.action)
            ACT_TICK: begin
                tick_channels();
            end
            ACT_EFFECT: begin
                if (snd_en && it.effect_id >= FX_FIRST && int'(it.effect_id) < EFFECT_COUNT
                    && !tune_on && fx_cnt[it.effect_id] != 0) begin
                    fx_sel = it.effect_id;
                    fx_pos = '0;
                    fx_left = '0;
                    effects_started++;
                    tick_channels();
                end
            end
            ACT_TUNE: begin
                if (snd_en) begin
                    tune_on = 1'b1;
                    tune_pos = '0;
                    tune_left = '0;
                    fx_sel = FX_NONE;
                    fx_left = '0;
                    tunes_started++;
                end
            end
            ACT_STOP_TUNE: begin
                tune_on = 1'b0;
                tune_pos = '0;
                tune_left = '0;
                tone_stop();
            end
            ACT_STOP_ALL: begin
                tone_stop();
                fx_sel = FX_NONE;
                fx_pos = '0;
                fx_left = '0;
                tune_on = 1'b0;
                tune_pos = '0;
                tune_left = '0;
            end
            default: begin
            end
        endcase
        rep.tone_on = spk_on;
        rep.tone_freq = spk_on ? spk_hz : F_REST;
        rep.tune_playing = tune_on;
        rep.effect_playing = fx_sel;
    endtask

    function automatic t_item pack_item(input logic [ACTION_W-1:0] a,
                                        input logic [EFFECT_W-1:0] id, input logic own);
        t_item it;
        it.action = a;
        it.effect_id = id;
        it.speaker_owned = own;
        return it;
    endfunction

    function automatic logic mostly_owned();
        return $urandom_range(0, 9) != 0;
    endfunction

    task automatic plan_item(input logic [ACTION_W-1:0] a, input logic [EFFECT_W-1:0] id,
                             input logic own, input logic typed, input t_result want);
        t_plan_row row;
        row = '0;
        row.item = pack_item(a, id, own);
        row.typed = typed;
        row.want = want;
        opening_plan.push_back(row);
    endtask

    task automatic plan_config(input logic level);
        t_plan_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.level = level;
        opening_plan.push_back(row);
    endtask

    // Offer one action in a burst pattern and record its report once transferred.
    task automatic offer_item(input t_item it, input logic typed, input t_result want);
        int gap;
        t_result rep;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 2) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_action <= it.action;
        i_effect_id <= it.effect_id;
        i_speaker_owned <= it.speaker_owned;
        do @(posedge i_clk); while (o_in_stall);
        advance_melody(it, rep);
        tone_reports_due.push_back(typed ? want : rep);
        actions_sent++;
    endtask

    // Stop offering and wait until every due report has been transferred.
    task automatic wait_reports_in();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tone_reports_due.size() != 0);
    endtask

    // Write the sound enable register, then read it back in a second transfer.
    task automatic set_sound_enable(input logic level);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SOUND_EN_ADDR;
        pwdata <= PDATA_W'(level);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        snd_en = level;
        settings_applied++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== PDATA_W'(level)) begin
            faults++;
            $display("%0t: sound enable read back: expected %0h, actual %0h", $time,
                     PDATA_W'(level), prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Output side: the stall pattern changes over random spans; one long hold-off.
    initial begin : receiver
        int mode;
        int span;
        int phase;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            span = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
            for (phase = 0; phase < span; phase++) begin
                @(posedge i_clk);
                if (hold_req) begin
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 99) < 30);
                    2: i_out_stall <= ($urandom_range(0, 99) < 70);
                    default: i_out_stall <= ((phase % 7) < 3);
                endcase
            end
        end
    end

    // Compare each transferred report with the oldest one due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tone_reports_due.size() == 0) begin
                faults++;
                $display("%0t: report with none due: tone %0b freq %0d tune %0b effect %0d",
                         $time, o_tone_on, o_tone_freq, o_tune_playing, o_effect_playing);
            end else begin
                report_want = tone_reports_due.pop_front();
                reports_checked++;
                if ({o_tone_on, o_tone_freq, o_tune_playing, o_effect_playing} !== report_want)
                begin
                    faults++;
                    $display("%0t: expected tone %0b freq %0d tune %0b effect %0d, actual tone %0b freq %0d tune %0b effect %0d",
                             $time, report_want.tone_on, report_want.tone_freq,
                             report_want.tune_playing, report_want.effect_playing,
                             o_tone_on, o_tone_freq, o_tune_playing, o_effect_playing);
                end
            end
        end
    end

    // Stimulus: opening table, then random effect and tune sequences.
    initial begin : stimulus
        int k;
        int n;
        int kind;
        int sent_random;
        int next_cfg;
        bit hold_done;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_TICK;
        i_effect_id = FX_NONE;
        i_speaker_owned = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values, unknown actions and invalid effect numbers.
        plan_item(ACT_TICK, FX_NONE, 1'b1, 1'b1, SILENT);
        plan_item(ACT_UNUSED_FIRST, FX_UNUSED, 1'b1, 1'b1, SILENT);
        plan_item(ACT_UNUSED_LAST, FX_LAST, 1'b0, 1'b1, SILENT);
        plan_item(ACT_EFFECT, FX_NONE, 1'b1, 1'b1, SILENT);
        plan_item(ACT_EFFECT, FX_UNUSED, 1'b1, 1'b1, SILENT);
        // A one-note effect sounds at once and ends on the next tick.
        plan_item(ACT_EFFECT, FX_FIRST, 1'b1, 1'b1, FIRST_FX_NOTE);
        plan_item(ACT_TICK, FX_UNUSED, 1'b1, 1'b0, SILENT);
        // The tune blocks effects; stopping it silences the speaker.
        plan_item(ACT_TUNE, FX_NONE, 1'b1, 1'b1, TUNE_ONLY);
        plan_item(ACT_TICK, FX_NONE, 1'b1, 1'b0, SILENT);
        plan_item(ACT_EFFECT, FX_ARPEG, 1'b1, 1'b0, SILENT);
        plan_item(ACT_STOP_TUNE, FX_NONE, 1'b1, 1'b1, SILENT);
        // Refused first tone, then notes that advance up to a long one.
        plan_item(ACT_EFFECT, FX_SCALE, 1'b0, 1'b0, SILENT);
        plan_item(ACT_TICK, FX_NONE, 1'b1, 1'b0, SILENT);
        plan_item(ACT_TICK, FX_NONE, 1'b1, 1'b0, SILENT);
        plan_item(ACT_TICK, FX_NONE, 1'b1, 1'b0, SILENT);
        plan_item(ACT_TICK, FX_NONE, 1'b1, 1'b0, SILENT);
        // Sound off mid-note: the tone holds until the note ends, no play starts.
        plan_config(1'b0);
        plan_item(ACT_TICK, FX_NONE, 1'b1, 1'b0, SILENT);
        plan_item(ACT_TUNE, FX_NONE, 1'b1, 1'b0, SILENT);
        plan_item(ACT_EFFECT, FX_CHIME, 1'b1, 1'b0, SILENT);
        plan_item(ACT_TICK, FX_NONE, 1'b1, 1'b0, SILENT);
        plan_config(1'b1);
        // Stop tune while an effect sounds keeps the effect selected.
        plan_item(ACT_EFFECT, FX_FALL, 1'b1, 1'b0, SILENT);
        plan_item(ACT_STOP_TUNE, FX_NONE, 1'b1, 1'b0, SILENT);
        plan_item(ACT_TICK, FX_NONE, 1'b1, 1'b0, SILENT);
        plan_item(ACT_STOP_ALL, FX_NONE, 1'b0, 1'b1, SILENT);

        for (k = 0; k < opening_plan.size(); k++) begin
            if (opening_plan[k].is_cfg) begin
                wait_reports_in();
                set_sound_enable(opening_plan[k].level);
            end else begin
                offer_item(opening_plan[k].item, opening_plan[k].typed, opening_plan[k].want);
            end
        end

        // Random sequences with sound-enable phases and one long output hold-off.
        sent_random = 0;
        next_cfg = 250;
        hold_done = 1'b0;
        while (sent_random < RANDOM_ITEMS) begin
            if (sent_random >= next_cfg) begin
                wait_reports_in();
                set_sound_enable(!snd_en);
                next_cfg = sent_random + (snd_en ? 250 : 70);
            end
            if (!hold_done && sent_random >= 500) begin
                hold_req = 1'b1;
                burst_left = 60;
                hold_done = 1'b1;
            end
            melody_batch.delete();
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // Effect followed by enough ticks to finish it most of the time.
                melody_batch.push_back(pack_item(ACT_EFFECT,
                    EFFECT_W'($urandom_range(FX_FIRST, FX_LAST)), mostly_owned()));
                n = $urandom_range(1, 12);
                repeat (n) melody_batch.push_back(pack_item(ACT_TICK, EFFECT_W'($urandom),
                                                            mostly_owned()));
            end else if (kind < 55) begin
                // Tune, often played to its end.
                melody_batch.push_back(pack_item(ACT_TUNE, EFFECT_W'($urandom), mostly_owned()));
                n = $urandom_range(5, 60);
                repeat (n) melody_batch.push_back(pack_item(ACT_TICK, EFFECT_W'($urandom),
                                                            mostly_owned()));
                if ($urandom_range(0, 4) == 0)
                    melody_batch.push_back(pack_item(ACT_STOP_TUNE, EFFECT_W'($urandom),
                                                     mostly_owned()));
            end else if (kind < 65) begin
                // Effect requests against a playing tune, then after stopping it.
                melody_batch.push_back(pack_item(ACT_TUNE, FX_NONE, mostly_owned()));
                n = $urandom_range(2, 6);
                repeat (n) melody_batch.push_back(pack_item(ACT_TICK, FX_NONE, mostly_owned()));
                melody_batch.push_back(pack_item(ACT_EFFECT,
                    EFFECT_W'($urandom_range(FX_FIRST, FX_LAST)), mostly_owned()));
                n = $urandom_range(2, 6);
                repeat (n) melody_batch.push_back(pack_item(ACT_TICK, FX_NONE, mostly_owned()));
                melody_batch.push_back(pack_item(ACT_STOP_TUNE, FX_NONE, mostly_owned()));
                melody_batch.push_back(pack_item(ACT_EFFECT,
                    EFFECT_W'($urandom_range(FX_FIRST, FX_LAST)), mostly_owned()));
                n = $urandom_range(1, 8);
                repeat (n) melody_batch.push_back(pack_item(ACT_TICK, FX_NONE, mostly_owned()));
            end else if (kind < 73) begin
                // Effect cut short by a stop.
                melody_batch.push_back(pack_item(ACT_EFFECT,
                    EFFECT_W'($urandom_range(FX_FIRST, FX_LAST)), mostly_owned()));
                n = $urandom_range(0, 3);
                repeat (n) melody_batch.push_back(pack_item(ACT_TICK, FX_NONE, mostly_owned()));
                melody_batch.push_back(pack_item($urandom_range(0, 1) ? ACT_STOP_ALL
                                                                      : ACT_STOP_TUNE,
                                                 EFFECT_W'($urandom), mostly_owned()));
                n = $urandom_range(1, 3);
                repeat (n) melody_batch.push_back(pack_item(ACT_TICK, FX_NONE, mostly_owned()));
            end else begin
                // Noise over every action code and effect number.
                n = $urandom_range(1, 6);
                repeat (n) melody_batch.push_back(pack_item(ACTION_W'($urandom_range(0, 7)),
                    EFFECT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            end
            foreach (melody_batch[k]) begin
                offer_item(melody_batch[k], 1'b0, SILENT);
                sent_random++;
            end
        end

        wait_reports_in();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d actions under %0d sound-enable writes: %0d effects and %0d tunes started, %0d tunes played out.",
                 actions_sent, settings_applied, effects_started, tunes_started, tunes_finished);
        $display("Compared %0d tone reports field by field; %0d faults.", reports_checked, faults);
        if (faults == 0) begin
            $display("two_channel_tone_sequencer_top: match");
        end else begin
            $display("two_channel_tone_sequencer_top: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/tcts_pkg.sv
hw/rtl/tcts_apb.sv
hw/rtl/tcts_core.sv
hw/rtl/two_channel_tone_sequencer_top.sv
tb/two_channel_tone_sequencer_top_tb.sv
